FILE: design/abmw_pkg.sv
`timescale 1ns / 1ps

package abmw_pkg;

    // Fixed field widths
    localparam int COEF_W    = 32;
    localparam int POS_W     = 12;
    localparam int VAL_W     = 8;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 3;

    // Mapped point carries 17 fraction bits (centre in half-pixel units)
    localparam int PT_FRAC = 17;
    // Product of a coefficient and a 13-bit centre, and the accumulated point
    localparam int PROD_W  = 46;
    localparam int ACC_W   = 47;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_XX     = 3'd0,
        CFG_COEF_XY     = 3'd1,
        CFG_COEF_YX     = 3'd2,
        CFG_COEF_YY     = 3'd3,
        CFG_SHIFT_X     = 3'd4,
        CFG_SHIFT_Y     = 3'd5,
        CFG_MASK_WIDTH  = 3'd6,
        CFG_MASK_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [VAL_W-1:0] val;
    } t_req;

    typedef struct packed {
        logic [COEF_W-1:0] xx;
        logic [COEF_W-1:0] xy;
        logic [COEF_W-1:0] yx;
        logic [COEF_W-1:0] yy;
        logic [COEF_W-1:0] sx;
        logic [COEF_W-1:0] sy;
    } t_xform;

endpackage

FILE: design/affine_bilinear_mask_warp_core.sv
`timescale 1ns / 1ps
// A sample request passes through eight register stages before its coverage
// result reaches the output.
// Throughput: one request per cycle (load or sample) while output is free;
// the mask sits in four parity banks so all four neighbors are read at once.
// Reset: synchronous, active low; clears valid bits and loads the identity
// transform and a 256x256 mask size. Mask bytes are undefined until loaded.
module affine_bilinear_mask_warp_core import abmw_pkg::*; #(
    parameter int MASK_DIM  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [VAL_W-1:0]     i_mask_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [VAL_W-1:0]     o_coverage,
    output logic [POS_W-1:0]     o_dest_x,
    output logic [POS_W-1:0]     o_dest_y,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    t_xform r_xform;
    logic [DIM_W-1:0] r_mask_width, r_mask_height;
    t_req req, map_req;
    logic map_valid, map_up_en, fetch_up_en, blend_up_en;
    logic signed [ACC_W-1:0] map_ax, map_ay;
    logic fetch_valid;
    logic [VAL_W-1:0] fetch_cell [4];
    logic [FRAC_BITS-1:0] fetch_fx, fetch_fy;
    logic [POS_W-1:0] fetch_dx, fetch_dy;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xform.xx    <= 32'h0001_0000;
            r_xform.xy    <= '0;
            r_xform.yx    <= '0;
            r_xform.yy    <= 32'h0001_0000;
            r_xform.sx    <= '0;
            r_xform.sy    <= '0;
            r_mask_width  <= 9'd256;
            r_mask_height <= 9'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_XX:     r_xform.xx <= i_cfg_data;
                CFG_COEF_XY:     r_xform.xy <= i_cfg_data;
                CFG_COEF_YX:     r_xform.yx <= i_cfg_data;
                CFG_COEF_YY:     r_xform.yy <= i_cfg_data;
                CFG_SHIFT_X:     r_xform.sx <= i_cfg_data;
                CFG_SHIFT_Y:     r_xform.sy <= i_cfg_data;
                CFG_MASK_WIDTH:  r_mask_width <= i_cfg_data[DIM_W-1:0];
                CFG_MASK_HEIGHT: r_mask_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign req = '{func: i_func, x: i_pos_x, y: i_pos_y, val: i_mask_value};
    assign o_in_stall = !map_up_en;

    abmw_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_req     (req),
        .i_xform   (r_xform),
        .i_down_en (fetch_up_en),
        .o_up_en   (map_up_en),
        .o_valid   (map_valid),
        .o_req     (map_req),
        .o_ax      (map_ax),
        .o_ay      (map_ay)
    );

    abmw_fetch #(.MASK_DIM(MASK_DIM), .FRAC_BITS(FRAC_BITS)) u_fetch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (map_valid),
        .i_req         (map_req),
        .i_ax          (map_ax),
        .i_ay          (map_ay),
        .i_mask_width  (r_mask_width),
        .i_mask_height (r_mask_height),
        .i_down_en     (blend_up_en),
        .o_up_en       (fetch_up_en),
        .o_valid       (fetch_valid),
        .o_cell        (fetch_cell),
        .o_fx          (fetch_fx),
        .o_fy          (fetch_fy),
        .o_dx          (fetch_dx),
        .o_dy          (fetch_dy)
    );

    abmw_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (fetch_valid),
        .i_cell     (fetch_cell),
        .i_fx       (fetch_fx),
        .i_fy       (fetch_fy),
        .i_dx       (fetch_dx),
        .i_dy       (fetch_dy),
        .i_stall    (i_out_stall),
        .o_up_en    (blend_up_en),
        .o_valid    (o_out_valid),
        .o_coverage (o_coverage),
        .o_dx       (o_dest_x),
        .o_dy       (o_dest_y)
    );

    // Input stalls only when a result is held at the output
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) |-> !o_in_stall)
        else $error("input stalled while output is free");

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A held result keeps its destination
    a_dest_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_dest_x)
                                          && $stable(o_dest_y)))
        else $error("held result changed");

endmodule

FILE: design/abmw_map.sv
`timescale 1ns / 1ps

module abmw_map import abmw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_req                    i_req,
    input  t_xform                  i_xform,
    input  logic                    i_down_en,
    output logic                    o_up_en,
    output logic                    o_valid,
    output t_req                    o_req,
    output logic signed [ACC_W-1:0] o_ax,
    output logic signed [ACC_W-1:0] o_ay
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (PT_FRAC - 1);

    logic r_v1, r_v2, r_v3;
    t_req r_req1, r_req2, r_req3;
    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [ACC_W-1:0]  r_ax, r_ay;
    logic en1, en2, en3;
    logic [POS_W:0] cx, cy;

    // Advance a stage when it is empty or the next one moves
    assign en3 = !r_v3 || i_down_en;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_up_en = en1;

    // Pixel centre in half-pixel units
    assign cx = {r_req1.x, 1'b1};
    assign cy = {r_req1.y, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Register request, then products, then sums
    always_ff @(posedge i_clk) begin
        if (en1) r_req1 <= i_req;
        if (en2) begin
            r_req2 <= r_req1;
            r_pxx  <= $signed(i_xform.xx) * $signed({1'b0, cx});
            r_pxy  <= $signed(i_xform.xy) * $signed({1'b0, cy});
            r_pyx  <= $signed(i_xform.yx) * $signed({1'b0, cx});
            r_pyy  <= $signed(i_xform.yy) * $signed({1'b0, cy});
        end
        if (en3) begin
            r_req3 <= r_req2;
            r_ax   <= ACC_W'(r_pxx) + ACC_W'(r_pxy)
                      + ACC_W'($signed({i_xform.sx, 1'b0})) - HALF;
            r_ay   <= ACC_W'(r_pyx) + ACC_W'(r_pyy)
                      + ACC_W'($signed({i_xform.sy, 1'b0})) - HALF;
        end
    end

    assign o_valid = r_v3;
    assign o_req   = r_req3;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;

endmodule

FILE: design/abmw_fetch.sv
`timescale 1ns / 1ps

module abmw_fetch import abmw_pkg::*; #(
    parameter int MASK_DIM  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_req                    i_req,
    input  logic signed [ACC_W-1:0] i_ax,
    input  logic signed [ACC_W-1:0] i_ay,
    input  logic [DIM_W-1:0]        i_mask_width,
    input  logic [DIM_W-1:0]        i_mask_height,
    input  logic                    i_down_en,
    output logic                    o_up_en,
    output logic                    o_valid,
    output logic [VAL_W-1:0]        o_cell [4],
    output logic [FRAC_BITS-1:0]    o_fx,
    output logic [FRAC_BITS-1:0]    o_fy,
    output logic [POS_W-1:0]        o_dx,
    output logic [POS_W-1:0]        o_dy
);

    localparam int CB    = $clog2(MASK_DIM);
    localparam int HALF  = (MASK_DIM + 1) / 2;
    localparam int DEPTH = HALF * HALF;
    localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = ACC_W - PT_FRAC;
    localparam int WW    = $clog2(MASK_DIM + 1);
    localparam int LW    = 2 * CB + 2;

    function automatic logic in_rng(input logic signed [XW:0] v, input logic [WW-1:0] lim);
        return !v[XW] && (v[XW-1:0] < XW'(lim));
    endfunction

    function automatic logic [AB-1:0] bank_addr(input logic [CB-1:0] col,
                                                input logic [CB-1:0] row);
        logic [LW-1:0] a;
        a = LW'(row >> 1) * LW'(HALF) + LW'(col >> 1);
        return a[AB-1:0];
    endfunction

    logic signed [XW:0] x0, x1, y0, y1;
    logic [WW-1:0] lim_w, lim_h;
    logic xin0, xin1, yin0, yin1;
    logic [PT_FRAC+FRAC_BITS-1:0] tx, ty;
    logic [AB-1:0] raddr [4];
    logic [3:0] wr_en;
    logic [AB-1:0] waddr;
    logic load_ok;
    logic en5;
    logic [VAL_W-1:0] rd [4];

    logic r_v5;
    logic [3:0] r_in;
    logic r_px, r_py;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic [POS_W-1:0] r_dx, r_dy;

    assign en5 = !r_v5 || i_down_en;
    assign o_up_en = en5;

    // Split the mapped point into base cell and fraction
    always_comb begin
        x0 = $signed(i_ax[ACC_W-1:PT_FRAC]);
        y0 = $signed(i_ay[ACC_W-1:PT_FRAC]);
        x1 = x0 + (XW+1)'(1);
        y1 = y0 + (XW+1)'(1);
        tx = {i_ax[PT_FRAC-1:0], {FRAC_BITS{1'b0}}};
        ty = {i_ay[PT_FRAC-1:0], {FRAC_BITS{1'b0}}};
        lim_w = (32'(i_mask_width) < MASK_DIM) ? WW'(i_mask_width) : WW'(MASK_DIM);
        lim_h = (32'(i_mask_height) < MASK_DIM) ? WW'(i_mask_height) : WW'(MASK_DIM);
        xin0 = in_rng(x0, lim_w);
        xin1 = in_rng(x1, lim_w);
        yin0 = in_rng(y0, lim_h);
        yin1 = in_rng(y1, lim_h);
    end

    // Pick the column and row each bank serves, one bank per parity pair
    always_comb begin
        logic signed [XW:0] cv, rv;
        for (int b = 0; b < 4; b++) begin
            cv = (x0[0] == b[0]) ? x0 : x1;
            rv = (y0[0] == b[1]) ? y0 : y1;
            if (in_rng(cv, WW'(MASK_DIM)) && in_rng(rv, WW'(MASK_DIM)))
                raddr[b] = bank_addr(cv[CB-1:0], rv[CB-1:0]);
            else
                raddr[b] = '0;
        end
    end

    // Decode a load into one bank write
    always_comb begin
        load_ok = i_valid && (i_req.func == FUNC_LOAD) && en5
                  && (32'(i_req.x) < MASK_DIM) && (32'(i_req.y) < MASK_DIM);
        waddr = bank_addr(i_req.x[CB-1:0], i_req.y[CB-1:0]);
        for (int b = 0; b < 4; b++)
            wr_en[b] = load_ok && (i_req.x[0] == b[0]) && (i_req.y[0] == b[1]);
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [VAL_W-1:0] mem [DEPTH];
        logic [VAL_W-1:0] r_rd;
        always_ff @(posedge i_clk) begin
            if (wr_en[g]) mem[waddr] <= i_req.val;
            if (en5) r_rd <= mem[raddr[g]];
        end
        assign rd[g] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en5) begin
            // Drop loads here: they give no result
            r_v5 <= i_valid && (i_req.func == FUNC_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_in <= {xin1 && yin1, xin0 && yin1, xin1 && yin0, xin0 && yin0};
            r_px <= x0[0];
            r_py <= y0[0];
            r_fx <= tx[PT_FRAC+FRAC_BITS-1:PT_FRAC];
            r_fy <= ty[PT_FRAC+FRAC_BITS-1:PT_FRAC];
            r_dx <= i_req.x;
            r_dy <= i_req.y;
        end
    end

    // Route bank data to neighbors, zero those outside the mask
    always_comb begin
        for (int n = 0; n < 4; n++)
            o_cell[n] = r_in[n] ? rd[{r_py ^ n[1], r_px ^ n[0]}] : '0;
    end

    assign o_valid = r_v5;
    assign o_fx = r_fx;
    assign o_fy = r_fy;
    assign o_dx = r_dx;
    assign o_dy = r_dy;

endmodule

FILE: design/abmw_blend.sv
`timescale 1ns / 1ps

module abmw_blend import abmw_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [VAL_W-1:0]     i_cell [4],
    input  logic [FRAC_BITS-1:0] i_fx,
    input  logic [FRAC_BITS-1:0] i_fy,
    input  logic [POS_W-1:0]     i_dx,
    input  logic [POS_W-1:0]     i_dy,
    input  logic                 i_stall,
    output logic                 o_up_en,
    output logic                 o_valid,
    output logic [VAL_W-1:0]     o_coverage,
    output logic [POS_W-1:0]     o_dx,
    output logic [POS_W-1:0]     o_dy
);

    localparam int WTW = FRAC_BITS + 1;
    localparam int PW  = VAL_W + WTW;
    localparam int TW  = PW + 1;
    localparam int BW  = TW + WTW;
    localparam int QW  = BW + 1 - 2 * FRAC_BITS;
    localparam logic [WTW-1:0] ONE = WTW'(1) << FRAC_BITS;
    localparam logic [BW:0]    RND = (BW+1)'(1) << (2 * FRAC_BITS - 1);

    logic r_v6, r_v7, r_v8, r_v9;
    logic en6, en7, en8, en9;
    logic [PW-1:0] r_p [4];
    logic [FRAC_BITS-1:0] r_fy6, r_fy7;
    logic [TW-1:0] r_top, r_bot;
    logic [BW-1:0] r_bt, r_bb;
    logic [POS_W-1:0] r_dx6, r_dy6, r_dx7, r_dy7, r_dx8, r_dy8, r_dx9, r_dy9;
    logic [VAL_W-1:0] r_cov;
    logic [WTW-1:0] wx [2];
    logic [BW:0] sum;
    logic [QW-1:0] q;

    assign en9 = !r_v9 || !i_stall;
    assign en8 = !r_v8 || en9;
    assign en7 = !r_v7 || en8;
    assign en6 = !r_v6 || en7;
    assign o_up_en = en6;

    assign wx[0] = ONE - WTW'(i_fx);
    assign wx[1] = WTW'(i_fx);

    // Round half up and saturate
    assign sum = (BW+1)'(r_bt) + (BW+1)'(r_bb) + RND;
    assign q   = sum[BW:2*FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else begin
            if (en6) r_v6 <= i_valid;
            if (en7) r_v7 <= r_v6;
            if (en8) r_v8 <= r_v7;
            if (en9) r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        // Weight each neighbor along x
        if (en6) begin
            for (int n = 0; n < 4; n++)
                r_p[n] <= PW'(i_cell[n]) * PW'(wx[n % 2]);
            r_fy6 <= i_fy;
            r_dx6 <= i_dx;
            r_dy6 <= i_dy;
        end
        // Sum rows
        if (en7) begin
            r_top <= TW'(r_p[0]) + TW'(r_p[1]);
            r_bot <= TW'(r_p[2]) + TW'(r_p[3]);
            r_fy7 <= r_fy6;
            r_dx7 <= r_dx6;
            r_dy7 <= r_dy6;
        end
        // Weight rows along y
        if (en8) begin
            r_bt  <= BW'(r_top) * BW'(ONE - WTW'(r_fy7));
            r_bb  <= BW'(r_bot) * BW'(r_fy7);
            r_dx8 <= r_dx7;
            r_dy8 <= r_dy7;
        end
        if (en9) begin
            r_cov <= (q > QW'(255)) ? 8'hFF : q[VAL_W-1:0];
            r_dx9 <= r_dx8;
            r_dy9 <= r_dy8;
        end
    end

    assign o_valid    = r_v9;
    assign o_coverage = r_cov;
    assign o_dx       = r_dx9;
    assign o_dy       = r_dy9;

endmodule

FILE: bench/affine_bilinear_mask_warp_core_tb.sv
`timescale 1ns / 1ps

module affine_bilinear_mask_warp_core_tb;
    import abmw_pkg::*;

    localparam int DIM  = 256;
    localparam int FRAC = 16;
    localparam int LAT  = 9;

    typedef struct {
        logic             func;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [VAL_W-1:0] val;
    } t_item;

    typedef struct {
        logic [VAL_W-1:0] cov;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_cov;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_func;
    logic [POS_W-1:0]     i_pos_x;
    logic [POS_W-1:0]     i_pos_y;
    logic [VAL_W-1:0]     i_mask_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [VAL_W-1:0]     o_coverage;
    logic [POS_W-1:0]     o_dest_x;
    logic [POS_W-1:0]     o_dest_y;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;

    affine_bilinear_mask_warp_core dut (.*);

    // Shadow copy of the block's state
    logic [COEF_W-1:0] m_xx, m_xy, m_yx, m_yy, m_sx, m_sy;
    logic [DIM_W-1:0]  m_w, m_h;
    logic [VAL_W-1:0]  mask_copy [DIM*DIM];
    bit                mask_known [DIM*DIM];

    t_item pending_reqs[$];
    t_cov  expected_cov[$];
    int    send_idle_pct, recv_stall_pct;
    int    errors, n_samples, n_loads, n_cov_checked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #500ms;
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [VAL_W-1:0] cell_at(longint cx, longint cy);
        longint w, h;
        w = (m_w < DIM) ? longint'(m_w) : DIM;
        h = (m_h < DIM) ? longint'(m_h) : DIM;
        if (cx < 0 || cy < 0 || cx >= w || cy >= h) return '0;
        return mask_copy[cy * DIM + cx];
    endfunction

    // Blend the four neighbors around the inverse-mapped pixel center
    function automatic logic [VAL_W-1:0] warp_coverage(logic [POS_W-1:0] px,
                                                        logic [POS_W-1:0] py);
        longint ax, ay, bx, by, fx, fy, one, top, bot, blend, cov;
        one = longint'(1) << FRAC;
        ax = longint'($signed(m_xx)) * (2 * px + 1) + longint'($signed(m_xy)) * (2 * py + 1)
             + 2 * longint'($signed(m_sx)) - (longint'(1) << (PT_FRAC - 1));
        ay = longint'($signed(m_yx)) * (2 * px + 1) + longint'($signed(m_yy)) * (2 * py + 1)
             + 2 * longint'($signed(m_sy)) - (longint'(1) << (PT_FRAC - 1));
        bx = ax >>> PT_FRAC;
        by = ay >>> PT_FRAC;
        fx = ((ax & ((longint'(1) << PT_FRAC) - 1)) << FRAC) >> PT_FRAC;
        fy = ((ay & ((longint'(1) << PT_FRAC) - 1)) << FRAC) >> PT_FRAC;
        top = cell_at(bx, by) * (one - fx) + cell_at(bx + 1, by) * fx;
        bot = cell_at(bx, by + 1) * (one - fx) + cell_at(bx + 1, by + 1) * fx;
        blend = top * (one - fy) + bot * fy;
        cov = (blend + (longint'(1) << (2 * FRAC - 1))) >>> (2 * FRAC);
        if (cov > 255) cov = 255;
        return cov[VAL_W-1:0];
    endfunction

    // Samples may only land on neighbors that were loaded; check all four
    function automatic bit sample_safe(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        longint ax, ay, bx, by, cx, cy, w, h;
        ax = longint'($signed(m_xx)) * (2 * px + 1) + longint'($signed(m_xy)) * (2 * py + 1)
             + 2 * longint'($signed(m_sx)) - (longint'(1) << (PT_FRAC - 1));
        ay = longint'($signed(m_yx)) * (2 * px + 1) + longint'($signed(m_yy)) * (2 * py + 1)
             + 2 * longint'($signed(m_sy)) - (longint'(1) << (PT_FRAC - 1));
        bx = ax >>> PT_FRAC;
        by = ay >>> PT_FRAC;
        w = (m_w < DIM) ? longint'(m_w) : DIM;
        h = (m_h < DIM) ? longint'(m_h) : DIM;
        for (int k = 0; k < 4; k++) begin
            cx = bx + (k & 1);
            cy = by + (k >> 1);
            if (cx >= 0 && cy >= 0 && cx < w && cy < h && !mask_known[cy * DIM + cx])
                return 0;
        end
        return 1;
    endfunction

    // Queue a request and update the shadow state in stimulus order
    task automatic push_req(logic func, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [VAL_W-1:0] v);
        t_item it;
        t_cov  c;
        it = '{func, x, y, v};
        if (func == FUNC_LOAD) begin
            if (x < DIM && y < DIM) begin
                mask_copy[y * DIM + x] = v;
                mask_known[y * DIM + x] = 1;
            end
            n_loads++;
        end else begin
            if (!sample_safe(x, y)) return;
            c = '{warp_coverage(x, y), x, y};
            expected_cov.push_back(c);
            n_samples++;
        end
        pending_reqs.push_back(it);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [COEF_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_COEF_XX:     m_xx = data;
            CFG_COEF_XY:     m_xy = data;
            CFG_COEF_YX:     m_yx = data;
            CFG_COEF_YY:     m_yy = data;
            CFG_SHIFT_X:     m_sx = data;
            CFG_SHIFT_Y:     m_sy = data;
            CFG_MASK_WIDTH:  m_w = data[DIM_W-1:0];
            CFG_MASK_HEIGHT: m_h = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_cov.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic set_xform(logic [COEF_W-1:0] xx, logic [COEF_W-1:0] xy,
                             logic [COEF_W-1:0] yx, logic [COEF_W-1:0] yy,
                             logic [COEF_W-1:0] sx, logic [COEF_W-1:0] sy,
                             int w, int h);
        write_reg(CFG_COEF_XX, xx);
        write_reg(CFG_COEF_XY, xy);
        write_reg(CFG_COEF_YX, yx);
        write_reg(CFG_COEF_YY, yy);
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_MASK_WIDTH, w);
        write_reg(CFG_MASK_HEIGHT, h);
    endtask

    // Random batch: loads and samples interleaved, mostly within a small window
    task automatic random_batch(int n);
        int start;
        start = n_loads + n_samples;
        while (n_loads + n_samples - start < n) begin
            case ($urandom_range(9))
                0, 1, 2: push_req(FUNC_LOAD, $urandom_range(15), $urandom_range(15),
                                  $urandom());
                3: push_req(FUNC_LOAD, $urandom(), $urandom(), $urandom());
                4: push_req(FUNC_SAMPLE, $urandom(), $urandom(), $urandom());
                default: push_req(FUNC_SAMPLE, $urandom_range(20), $urandom_range(20),
                                  $urandom());
            endcase
        end
    endtask

    // Drive requests from the queue, holding a stalled payload
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) void'(pending_reqs.pop_front());
            if ((i_in_valid && o_in_stall)) begin
                // hold
            end else if (pending_reqs.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                t_item nx;
                nx = pending_reqs[0];
                i_in_valid   <= 1'b1;
                i_func       <= nx.func;
                i_pos_x      <= nx.x;
                i_pos_y      <= nx.y;
                i_mask_value <= nx.val;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Check results against the oldest expectation and randomize stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_cov.size() == 0) begin
                    $display("%0t unexpected result cov=%0d x=%0d y=%0d", $time,
                             o_coverage, o_dest_x, o_dest_y);
                    errors++;
                end else begin
                    t_cov e;
                    e = expected_cov.pop_front();
                    n_cov_checked++;
                    if (o_coverage !== e.cov || o_dest_x !== e.x || o_dest_y !== e.y) begin
                        $display("%0t mismatch exp cov=%0d x=%0d y=%0d got cov=%0d x=%0d y=%0d",
                                 $time, e.cov, e.x, e.y, o_coverage, o_dest_x, o_dest_y);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_mask_value = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        m_xx = 32'h10000; m_xy = '0; m_yx = '0; m_yy = 32'h10000;
        m_sx = '0; m_sy = '0; m_w = 256; m_h = 256;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners of the mask, out-of-store loads, identity samples
        push_req(FUNC_LOAD, 0, 0, 8'hFF);
        push_req(FUNC_LOAD, 1, 0, 8'h00);
        push_req(FUNC_LOAD, 0, 1, 8'h80);
        push_req(FUNC_LOAD, 1, 1, 8'h7F);
        push_req(FUNC_LOAD, 255, 255, 8'hFF);
        push_req(FUNC_LOAD, 4095, 4095, 8'h55);
        push_req(FUNC_LOAD, 256, 3, 8'hAA);
        push_req(FUNC_SAMPLE, 0, 0, 8'hFF);
        push_req(FUNC_SAMPLE, 1, 1, 0);
        push_req(FUNC_SAMPLE, 255, 255, 0);
        push_req(FUNC_SAMPLE, 4095, 4095, 0);
        push_req(FUNC_SAMPLE, 4095, 0, 0);
        drain();

        // Sub-pixel shift, then extreme coefficients, then an all-zero matrix
        set_xform(32'h10000, 0, 0, 32'h10000, 32'h8000, 32'h4000, 2, 2);
        push_req(FUNC_SAMPLE, 0, 0, 0);
        push_req(FUNC_SAMPLE, 1, 0, 0);
        push_req(FUNC_SAMPLE, 0, 1, 0);
        drain();
        set_xform(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 1, 1);
        push_req(FUNC_SAMPLE, 0, 0, 0);
        push_req(FUNC_SAMPLE, 4095, 4095, 0);
        drain();
        set_xform(0, 0, 0, 0, 32'hFFFF8000, 32'hFFFF8000, 256, 256);
        push_req(FUNC_SAMPLE, 7, 9, 0);
        drain();

        // Random phases over idling patterns and transforms
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (ph == 4)
                set_xform(32'h0000C000, 32'h00002000, 32'hFFFFE000, 32'h00014000,
                          32'h00018000, 32'hFFFF0000, 9, 13);
            else if (ph == 6)
                set_xform($urandom_range(32'h20000), $urandom_range(32'h8000),
                          $urandom_range(32'h8000), $urandom_range(32'h20000),
                          $urandom_range(32'h40000), $urandom_range(32'h40000),
                          $urandom_range(1, 256), $urandom_range(1, 256));
            else if (ph == 7)
                set_xform(32'h10000, 0, 0, 32'h10000, 0, 0, 256, 256);
            random_batch(250);
            drain();
        end
        $display("covered %0d loads and %0d samples, %0d coverage results checked",
                 n_loads, n_samples, n_cov_checked);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
